@@ src/multi_slot_compare_timer_scheduler_defines.svh @@
// Assertion macros used by the scheduler controller.
// Each macro is defined twice: a checking form for simulation and an
// empty form for synthesis.
`ifndef MULTI_SLOT_COMPARE_TIMER_SCHEDULER_DEFINES_SVH
`define MULTI_SLOT_COMPARE_TIMER_SCHEDULER_DEFINES_SVH

`ifndef SYNTHESIS

// A property checked at every rising edge of i_clk outside reset.
`define MSCT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("msct assertion failed");

// A condition in one cycle implies another in the following cycle.
`define MSCT_ASSERT_NEXT(lbl, pre, post) \
    `MSCT_ASSERT(lbl, (pre) |=> (post))

`else

`define MSCT_ASSERT(lbl, prop)
`define MSCT_ASSERT_NEXT(lbl, pre, post)

`endif

`endif

@@ src/msct_pkg.sv @@
package msct_pkg;

    // Input opcodes.
    localparam logic [1:0] OP_ARM    = 2'd0;
    localparam logic [1:0] OP_DISARM = 2'd1;
    localparam logic [1:0] OP_CMP    = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_FIRE = 2'd0;
    localparam logic [1:0] KIND_SUM  = 2'd1;
    localparam logic [1:0] KIND_ACK  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_THRESHOLD   = 2'd0;
    localparam logic [1:0] CFG_MAX_COMPARE = 2'd1;
    localparam logic [1:0] CFG_MIN_LEAD    = 2'd2;

    // Configuration reset values.
    localparam logic [15:0] THRESHOLD_RST   = 16'd0;
    localparam logic [15:0] MAX_COMPARE_RST = 16'hFF00;
    localparam logic [9:0]  MIN_LEAD_RST    = 10'd20;

    // One slot table entry.
    typedef struct packed {
        logic        periodic;
        logic [15:0] tag;
        logic [23:0] reload;
        logic [31:0] remaining;
    } t_slot_ent;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;     // latch the accepted input item
        logic apply_ack;   // perform arm or disarm and load the acknowledge
        logic scan_rd;     // read one slot into the scan pipeline
        logic run_update;  // settle the running flag after a scan
        logic ld_fire;     // load the next queued fire result
        logic ld_sum;      // load the schedule summary
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
        logic pipe_busy;
    } t_dp_sts;

endpackage

@@ src/msct_ctrl.sv @@
`include "multi_slot_compare_timer_scheduler_defines.svh"

module msct_ctrl
    import msct_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic [1:0]    i_opcode,
    input  t_dp_sts       i_sts,
    input  logic [CW-1:0] i_fire_cnt,
    output t_dp_cmd       o_cmd,
    output logic [IW-1:0] o_scan_idx,
    output logic [IW-1:0] o_emit_idx
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_ACK   = 6'b000010,
        S_SCAN  = 6'b000100,
        S_DRAIN = 6'b001000,
        S_FIRE  = 6'b010000,
        S_SUM   = 6'b100000
    } t_state;

    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_k, n_k;
    logic [CW-1:0] k_inc;

    assign k_inc = CW'(r_k + 1'b1);

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_k     = r_k;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    case (i_opcode)
                        OP_ARM, OP_DISARM: begin
                            n_state = S_ACK;
                        end
                        OP_CMP: begin
                            n_state = S_SCAN;
                            n_idx   = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_ACK: begin
                if (i_sts.out_free) begin
                    o_cmd.apply_ack = 1'b1;
                    n_state         = S_IDLE;
                end
            end
            S_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = IW'(r_idx + 1'b1);
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    o_cmd.run_update = 1'b1;
                    n_k              = '0;
                    n_state          = (i_fire_cnt != '0) ? S_FIRE : S_SUM;
                end
            end
            S_FIRE: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_fire = 1'b1;
                    n_k           = k_inc;
                    if (k_inc == i_fire_cnt) begin
                        n_state = S_SUM;
                    end
                end
            end
            S_SUM: begin
                if (i_sts.out_free) begin
                    o_cmd.ld_sum = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_k     <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_k     <= n_k;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_scan_idx = r_idx;
    // The fire queue read is registered, so it follows the next index.
    assign o_emit_idx = n_k[IW-1:0];

    `MSCT_ASSERT(a_load_when_free, (o_cmd.apply_ack || o_cmd.ld_fire || o_cmd.ld_sum) |-> i_sts.out_free)
    `MSCT_ASSERT(a_fire_pipe_idle, (r_state == S_FIRE) |-> !i_sts.pipe_busy)
    `MSCT_ASSERT(a_fire_in_count, o_cmd.ld_fire |-> (r_k < i_fire_cnt))
    `MSCT_ASSERT_NEXT(a_scan_ends, (r_state == S_SCAN) && (r_idx == LAST_IDX), r_state == S_DRAIN)

endmodule

@@ src/msct_dp.sv @@
module msct_dp
    import msct_pkg::*;
#(
    parameter int SLOTS = 16,
    parameter int IW    = 4,
    parameter int CW    = 5
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_wdata,
    input  logic [1:0]    i_opcode,
    input  logic [3:0]    i_slot,
    input  logic [23:0]   i_interval,
    input  logic          i_periodic,
    input  logic [15:0]   i_timer_tag,
    input  logic [15:0]   i_elapsed_reference,
    input  logic [15:0]   i_counter_now,
    input  t_dp_cmd       i_cmd,
    input  logic [IW-1:0] i_scan_idx,
    input  logic [IW-1:0] i_emit_idx,
    output t_dp_sts       o_sts,
    output logic [CW-1:0] o_fire_cnt,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output logic [1:0]    o_kind,
    output logic [15:0]   o_fired_tag,
    output logic [15:0]   o_next_compare,
    output logic          o_running,
    output logic          o_last
);

    localparam int SW = (IW > 4) ? IW : 4;

    // Configuration.
    logic [15:0] r_thr;
    logic [15:0] r_max;
    logic [9:0]  r_lead;

    // Captured input item.
    logic [1:0]  r_op;
    logic [3:0]  r_slot;
    logic [23:0] r_interval;
    logic        r_periodic;
    logic [15:0] r_tag;
    logic [16:0] r_drop;
    logic [15:0] r_cv;

    // Slot state.
    logic [SLOTS-1:0] r_active;
    logic             r_running;
    t_slot_ent        r_mem [SLOTS];
    t_slot_ent        r_rd_q;
    logic [15:0]      r_fifo [SLOTS];
    logic [15:0]      r_fifo_q;
    logic [CW-1:0]    r_fire_cnt;

    // Scan pipeline.
    logic               r_s1_act;
    logic [IW-1:0]      r_s1_idx;
    logic               r_s2_act;
    logic [IW-1:0]      r_s2_idx;
    t_slot_ent          r_s2_ent;
    logic               r_s3_keep;
    logic [31:0]        r_s3_rem;
    logic signed [31:0] r_best;

    // Output register.
    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic [15:0] r_fired_tag;
    logic [15:0] r_next;
    logic        r_out_run;
    logic        r_last;

    logic [SW-1:0] slot_w;
    logic [IW-1:0] slot_addr;
    logic          in_range;
    logic          is_arm;
    t_slot_ent     arm_ent;
    logic [31:0]   s1_rem;
    t_slot_ent     s1_ent;
    logic          s2_fire;
    logic          s2_keep;
    t_slot_ent     s2_new_ent;
    logic [16:0]   floor_v;
    logic [31:0]   raised;
    logic [15:0]   next_cmp;
    logic          out_free;
    logic          ack_run;

    assign slot_w    = SW'(r_slot);
    assign slot_addr = slot_w[IW-1:0];
    assign in_range  = ({28'd0, r_slot} < 32'(SLOTS));
    assign is_arm    = (r_op == OP_ARM);
    assign ack_run   = (is_arm && in_range) || r_running;

    always_comb begin
        arm_ent.periodic  = r_periodic;
        arm_ent.tag       = r_tag;
        arm_ent.reload    = r_interval;
        arm_ent.remaining = {8'd0, r_interval};
    end

    // Stage one: subtract the elapsed count.
    assign s1_rem = r_rd_q.remaining - {15'd0, r_drop};

    always_comb begin
        s1_ent           = r_rd_q;
        s1_ent.remaining = s1_rem;
    end

    // Stage two: threshold test, reload or free.
    always_comb begin
        s2_fire    = r_s2_act && ($signed(r_s2_ent.remaining) <= $signed({16'd0, r_thr}));
        s2_new_ent = r_s2_ent;
        if (s2_fire && r_s2_ent.periodic) begin
            s2_new_ent.remaining = r_s2_ent.remaining + {8'd0, r_s2_ent.reload};
        end
        s2_keep = r_s2_act && !(s2_fire && !r_s2_ent.periodic);
    end

    // Summary: the minimum never exceeds max_compare since the search starts there.
    always_comb begin
        floor_v  = {1'b0, r_cv} + {7'd0, r_lead};
        raised   = (r_best < $signed({15'd0, floor_v})) ? {15'd0, floor_v} : r_best;
        next_cmp = (|raised[31:16]) ? 16'hFFFF : raised[15:0];
    end

    assign out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= THRESHOLD_RST;
            r_max  <= MAX_COMPARE_RST;
            r_lead <= MIN_LEAD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_THRESHOLD:   r_thr  <= i_cfg_wdata;
                CFG_MAX_COMPARE: r_max  <= i_cfg_wdata;
                CFG_MIN_LEAD:    r_lead <= i_cfg_wdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op       <= i_opcode;
            r_slot     <= i_slot;
            r_interval <= i_interval;
            r_periodic <= i_periodic;
            r_tag      <= i_timer_tag;
            r_drop     <= {1'b0, i_elapsed_reference} + {1'b0, i_counter_now};
            r_cv       <= i_counter_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active  <= '0;
            r_running <= 1'b0;
        end else begin
            if (i_cmd.apply_ack && in_range) begin
                r_active[slot_addr] <= is_arm;
            end else if (s2_fire && !r_s2_ent.periodic) begin
                r_active[r_s2_idx] <= 1'b0;
            end
            if (i_cmd.apply_ack && in_range && is_arm) begin
                r_running <= 1'b1;
            end else if (i_cmd.run_update && !(|r_active)) begin
                r_running <= 1'b0;
            end
        end
    end

    // Slot table: one write port, one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_ack && in_range && is_arm) begin
            r_mem[slot_addr] <= arm_ent;
        end else if (r_s2_act) begin
            r_mem[r_s2_idx] <= s2_new_ent;
        end
        if (i_cmd.scan_rd) begin
            r_rd_q <= r_mem[i_scan_idx];
        end
    end

    // Fire queue: tags in ascending slot order.
    always_ff @(posedge i_clk) begin
        if (s2_fire) begin
            r_fifo[r_fire_cnt[IW-1:0]] <= r_s2_ent.tag;
        end
        r_fifo_q <= r_fifo[i_emit_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_act   <= 1'b0;
            r_s2_act   <= 1'b0;
            r_s3_keep  <= 1'b0;
            r_fire_cnt <= '0;
        end else begin
            r_s1_act  <= i_cmd.scan_rd && r_active[i_scan_idx];
            r_s2_act  <= r_s1_act;
            r_s3_keep <= s2_keep;
            if (i_cmd.capture) begin
                r_fire_cnt <= '0;
            end else if (s2_fire) begin
                r_fire_cnt <= CW'(r_fire_cnt + 1'b1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_idx <= i_scan_idx;
        r_s2_idx <= r_s1_idx;
        r_s2_ent <= s1_ent;
        r_s3_rem <= s2_new_ent.remaining;
        if (i_cmd.capture) begin
            r_best <= $signed({16'd0, r_max});
        end else if (r_s3_keep && ($signed(r_s3_rem) < r_best)) begin
            r_best <= $signed(r_s3_rem);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.apply_ack || i_cmd.ld_fire || i_cmd.ld_sum) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.apply_ack) begin
            r_kind      <= KIND_ACK;
            r_fired_tag <= 16'd0;
            r_next      <= 16'd0;
            r_out_run   <= ack_run;
            r_last      <= 1'b1;
        end else if (i_cmd.ld_fire) begin
            r_kind      <= KIND_FIRE;
            r_fired_tag <= r_fifo_q;
            r_next      <= 16'd0;
            r_out_run   <= r_running;
            r_last      <= 1'b0;
        end else if (i_cmd.ld_sum) begin
            r_kind      <= KIND_SUM;
            r_fired_tag <= 16'd0;
            r_next      <= r_running ? next_cmp : 16'd0;
            r_out_run   <= r_running;
            r_last      <= 1'b1;
        end
    end

    assign o_sts.out_free   = out_free;
    assign o_sts.pipe_busy  = r_s1_act || r_s2_act || r_s3_keep;
    assign o_fire_cnt       = r_fire_cnt;

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_kind;
    assign o_fired_tag    = r_fired_tag;
    assign o_next_compare = r_next;
    assign o_running      = r_out_run;
    assign o_last         = r_last;

endmodule

@@ src/multi_slot_compare_timer_scheduler.sv @@
// Channel   Direction  Handshake                    Payload
// in        input      i_in_valid / o_in_ready      opcode, slot, interval, periodic,
//                                                   timer_tag, elapsed_reference,
//                                                   counter_now
// out       output     o_out_valid / i_out_ready    kind, fired_tag, next_compare,
//                                                   running, last
// cfg       input      i_cfg_we (no wait)           i_cfg_addr, i_cfg_wdata
//
// An arm or disarm item is accepted, then the table update and the acknowledge
// load follow once the output register is free. For a compare item the scan
// reads one slot per cycle from the slot table through a three stage pipeline,
// then the fired tags are emitted one per cycle from the fire queue while the
// output is not stalled, then the summary.
// Reset is synchronous and active low; it clears all slots and the running flag.
// A stalled output holds the block in place; the next item is accepted once
// the last result of the current one sits in the output register.
module multi_slot_compare_timer_scheduler
    import msct_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_opcode,
    input  logic [3:0]  i_slot,
    input  logic [23:0] i_interval,
    input  logic        i_periodic,
    input  logic [15:0] i_timer_tag,
    input  logic [15:0] i_elapsed_reference,
    input  logic [15:0] i_counter_now,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [15:0] o_fired_tag,
    output logic [15:0] o_next_compare,
    output logic        o_running,
    output logic        o_last
);

    // Slot index width, and fire count width which must also hold SLOTS itself.
    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [CW-1:0] fire_cnt;
    logic [IW-1:0] scan_idx;
    logic [IW-1:0] emit_idx;

    // The controller sequences the scan, the fire emission and the summary.
    msct_ctrl #(
        .SLOTS (SLOTS),
        .IW    (IW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_opcode   (i_opcode),
        .i_sts      (sts),
        .i_fire_cnt (fire_cnt),
        .o_cmd      (cmd),
        .o_scan_idx (scan_idx),
        .o_emit_idx (emit_idx)
    );

    // The datapath holds the slot table, the fire queue, the countdown
    // pipeline, the configuration and the output register.
    msct_dp #(
        .SLOTS (SLOTS),
        .IW    (IW),
        .CW    (CW)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_addr          (i_cfg_addr),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_opcode            (i_opcode),
        .i_slot              (i_slot),
        .i_interval          (i_interval),
        .i_periodic          (i_periodic),
        .i_timer_tag         (i_timer_tag),
        .i_elapsed_reference (i_elapsed_reference),
        .i_counter_now       (i_counter_now),
        .i_cmd               (cmd),
        .i_scan_idx          (scan_idx),
        .i_emit_idx          (emit_idx),
        .o_sts               (sts),
        .o_fire_cnt          (fire_cnt),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_kind              (o_kind),
        .o_fired_tag         (o_fired_tag),
        .o_next_compare      (o_next_compare),
        .o_running           (o_running),
        .o_last              (o_last)
    );

endmodule

@@ dv/tb_top.sv @@
// Self-checking bench for the multi-slot compare timer scheduler.
module tb_top;
    import msct_pkg::*;

    localparam int SLOTS = 16;

    // Opcode 3 is not decoded by the block: it is swallowed without a result.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // A compare item walks every slot, drains the fire queue and then loads the
    // summary, so this is a safe bound on how long the block can stay busy
    // after its last visible result.
    localparam int SETTLE_CYCLES = 2 * SLOTS + 16;

    // Cycles without any accepted item before the run is declared hung.
    localparam int HANG_LIMIT = 2000;

    localparam int RANDOM_ITEMS_PER_PHASE = 23;

    typedef struct {
        logic [1:0]  opcode;
        logic [3:0]  slot;
        logic [23:0] interval;
        logic        periodic;
        logic [15:0] tag;
        logic [15:0] elapsed;
        logic [15:0] counter;
    } t_timer_cmd;

    typedef struct {
        logic [1:0]  kind;
        logic [15:0] tag;
        logic [15:0] next_cmp;
        logic        running;
        logic        last;
    } t_timer_report;

    // Clock, reset and configuration port.
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = CFG_THRESHOLD;
    logic [15:0] cfg_wdata = 16'd0;

    // Input item channel.
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  opcode = OP_ARM;
    logic [3:0]  slot = 4'd0;
    logic [23:0] interval = 24'd0;
    logic        periodic = 1'b0;
    logic [15:0] timer_tag = 16'd0;
    logic [15:0] elapsed_reference = 16'd0;
    logic [15:0] counter_now = 16'd0;

    // Result channel.
    logic        out_valid;
    logic        out_ready = 1'b1;
    logic [1:0]  kind;
    logic [15:0] fired_tag;
    logic [15:0] next_compare;
    logic        running;
    logic        last;

    // Idling knobs, in percent per cycle.
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // Bookkeeping for the final verdict and the coverage summary.
    int mismatch_count = 0;
    int items_sent = 0;
    int results_checked = 0;
    int fires_seen = 0;
    int summaries_seen = 0;
    int settings_used = 1;

    // Shadow copy of the slot table and registers, advanced item by item.
    logic        tbl_active [SLOTS];
    logic        tbl_periodic [SLOTS];
    logic [15:0] tbl_tag [SLOTS];
    logic [23:0] tbl_reload [SLOTS];
    logic [31:0] tbl_remaining [SLOTS];
    logic        tbl_running;
    logic [15:0] cfg_threshold;
    logic [15:0] cfg_max_compare;
    logic [9:0]  cfg_min_lead;

    // Reports still owed by the block, oldest first.
    t_timer_report timer_reports_q[$];

    multi_slot_compare_timer_scheduler #(
        .SLOTS(SLOTS)
    ) dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_cfg_we            (cfg_we),
        .i_cfg_addr          (cfg_addr),
        .i_cfg_wdata         (cfg_wdata),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_opcode            (opcode),
        .i_slot              (slot),
        .i_interval          (interval),
        .i_periodic          (periodic),
        .i_timer_tag         (timer_tag),
        .i_elapsed_reference (elapsed_reference),
        .i_counter_now       (counter_now),
        .o_out_valid         (out_valid),
        .i_out_ready         (out_ready),
        .o_kind              (kind),
        .o_fired_tag         (fired_tag),
        .o_next_compare      (next_compare),
        .o_running           (running),
        .o_last              (last)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    // The receiver decides on its ready at every falling edge, so a stall can
    // land on any cycle of the scan, the fire drain or the summary.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        $display("tb: mismatch at %0t: %s", $time, msg);
    endtask

    // Advance the shadow table by one accepted item and queue the reports
    // that the block owes for it.
    task automatic advance_timer_table(input t_timer_cmd c);
        logic [31:0]   drop;
        longint        best;
        longint        lead_floor;
        longint        rem_s;
        longint        thr;
        bit            found;
        logic [15:0]   nxt;
        t_timer_report rep;
        t_timer_report fired[$];

        thr = longint'(cfg_threshold);
        case (c.opcode)
            OP_ARM, OP_DISARM: begin
                if (c.opcode == OP_ARM) begin
                    tbl_active[c.slot] = 1'b1;
                    tbl_periodic[c.slot] = c.periodic;
                    tbl_tag[c.slot] = c.tag;
                    tbl_reload[c.slot] = c.interval;
                    tbl_remaining[c.slot] = {8'd0, c.interval};
                    tbl_running = 1'b1;
                end else begin
                    // A disarm frees the slot but leaves the running flag
                    // alone until the next compare item.
                    tbl_active[c.slot] = 1'b0;
                end
                rep = '{KIND_ACK, 16'd0, 16'd0, tbl_running, 1'b1};
                timer_reports_q.push_back(rep);
            end
            OP_CMP: begin
                drop = {16'd0, c.elapsed} + {16'd0, c.counter};
                best = longint'(cfg_max_compare);
                found = 1'b0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (!tbl_active[i])
                        continue;
                    tbl_remaining[i] = tbl_remaining[i] - drop;
                    rem_s = longint'($signed(tbl_remaining[i]));
                    // The count is signed: an overshoot past zero still fires.
                    if (rem_s <= thr) begin
                        if (tbl_periodic[i])
                            tbl_remaining[i] = tbl_remaining[i] + {8'd0, tbl_reload[i]};
                        else
                            tbl_active[i] = 1'b0;
                        rep = '{KIND_FIRE, tbl_tag[i], 16'd0, 1'b0, 1'b0};
                        fired.push_back(rep);
                    end
                    if (tbl_active[i]) begin
                        rem_s = longint'($signed(tbl_remaining[i]));
                        found = 1'b1;
                        if (rem_s < best)
                            best = rem_s;
                    end
                end
                if (found) begin
                    // Cap at the ceiling, then keep the compare far enough
                    // ahead of the counter, saturating at the counter width.
                    lead_floor = longint'(c.counter) + longint'(cfg_min_lead);
                    if (best > longint'(cfg_max_compare))
                        best = longint'(cfg_max_compare);
                    if (best < lead_floor)
                        best = lead_floor;
                    if (best > 65535)
                        best = 65535;
                    nxt = best[15:0];
                end else begin
                    tbl_running = 1'b0;
                    nxt = 16'd0;
                end
                // Fire reports carry the running flag as it stands after the scan.
                foreach (fired[k]) begin
                    fired[k].running = tbl_running;
                    timer_reports_q.push_back(fired[k]);
                end
                rep = '{KIND_SUM, 16'd0, nxt, tbl_running, 1'b1};
                timer_reports_q.push_back(rep);
            end
            default: begin
            end
        endcase
    endtask

    // Every accepted result is matched against the oldest owed report.
    always @(posedge clk) begin
        t_timer_report want;
        if (rst_n && out_valid && out_ready) begin
            results_checked++;
            if (kind == KIND_FIRE)
                fires_seen++;
            if (kind == KIND_SUM)
                summaries_seen++;
            if (timer_reports_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result kind=%0d tag=%h next=%h",
                                          kind, fired_tag, next_compare));
            end else begin
                want = timer_reports_q.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %0d", kind, want.kind));
                if (fired_tag !== want.tag)
                    report_mismatch($sformatf("fired_tag %h, expected %h",
                                              fired_tag, want.tag));
                if (next_compare !== want.next_cmp)
                    report_mismatch($sformatf("next_compare %h, expected %h",
                                              next_compare, want.next_cmp));
                if (running !== want.running)
                    report_mismatch($sformatf("running %b, expected %b",
                                              running, want.running));
                if (last !== want.last)
                    report_mismatch($sformatf("last %b, expected %b", last, want.last));
            end
        end
    end

    // Hang detector: any accepted item on either channel restarts the count.
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < HANG_LIMIT) begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb: timeout after %0d quiet cycles", HANG_LIMIT);
        $display("tb: failure");
        $finish;
    end

    // Offer one item and hold it until the block takes it. Called and left at
    // a falling edge; valid stays high afterwards so back-to-back items need
    // no gap, and it only drops when the sender chooses to idle.
    task automatic send_item(input t_timer_cmd c);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        opcode <= c.opcode;
        slot <= c.slot;
        interval <= c.interval;
        periodic <= c.periodic;
        timer_tag <= c.tag;
        elapsed_reference <= c.elapsed;
        counter_now <= c.counter;
        do
            @(posedge clk);
        while (!in_ready);
        advance_timer_table(c);
        items_sent++;
        @(negedge clk);
    endtask

    function automatic t_timer_cmd make_cmd(input logic [1:0] op, input logic [3:0] s,
                                            input logic [23:0] ivl, input logic per,
                                            input logic [15:0] tg, input logic [15:0] el,
                                            input logic [15:0] cnt);
        t_timer_cmd c;
        c = '{op, s, ivl, per, tg, el, cnt};
        return c;
    endfunction

    // Random item: mostly arms and compares with small counts so slots fire
    // often, some disarms, and a sprinkle of full-range values and dead opcodes.
    function automatic t_timer_cmd make_random_cmd();
        t_timer_cmd c;
        int roll;
        roll = $urandom_range(99);
        if (roll < 45)
            c.opcode = OP_ARM;
        else if (roll < 60)
            c.opcode = OP_DISARM;
        else if (roll < 97)
            c.opcode = OP_CMP;
        else
            c.opcode = OP_UNUSED;
        c.slot = 4'($urandom_range(SLOTS - 1));
        c.periodic = 1'($urandom_range(1));
        c.tag = 16'($urandom_range(16'hFFFF));
        roll = $urandom_range(99);
        if (roll < 70)
            c.interval = 24'($urandom_range(3000));
        else if (roll < 90)
            c.interval = 24'($urandom_range(65535));
        else
            c.interval = 24'($urandom_range(24'hFFFFFF));
        if ($urandom_range(99) < 80) begin
            c.elapsed = 16'($urandom_range(600));
            c.counter = 16'($urandom_range(600));
        end else begin
            c.elapsed = 16'($urandom_range(16'hFFFF));
            c.counter = 16'($urandom_range(16'hFFFF));
        end
        return c;
    endfunction

    // Hold off the sender until the block owes nothing more.
    task automatic drain_reports();
        in_valid <= 1'b0;
        while (timer_reports_q.size() != 0)
            @(negedge clk);
    endtask

    // Drain, then give a dead opcode that is still in flight time to pass.
    task automatic quiesce();
        drain_reports();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Registers are only written with the block idle.
    task automatic write_register(input logic [1:0] idx, input logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        case (idx)
            CFG_THRESHOLD:   cfg_threshold = value;
            CFG_MAX_COMPARE: cfg_max_compare = value;
            CFG_MIN_LEAD:    cfg_min_lead = value[9:0];
            default: begin
            end
        endcase
    endtask

    task automatic apply_setting(input logic [15:0] thr, input logic [15:0] max_cmp,
                                 input logic [9:0] lead);
        quiesce();
        write_register(CFG_THRESHOLD, thr);
        write_register(CFG_MAX_COMPARE, max_cmp);
        write_register(CFG_MIN_LEAD, {6'd0, lead});
        settings_used++;
    endtask

    // One stretch of random items. Halfway through, the sender waits for the
    // block to catch up completely before carrying on.
    task automatic run_random_phase(input int idle_pct, input int stall_pct);
        int counted;
        bit paused;
        t_timer_cmd c;
        counted = 0;
        paused = 1'b0;
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        while (counted < RANDOM_ITEMS_PER_PHASE) begin
            c = make_random_cmd();
            send_item(c);
            if (c.opcode != OP_UNUSED)
                counted++;
            if (!paused && counted >= RANDOM_ITEMS_PER_PHASE / 2) begin
                drain_reports();
                paused = 1'b1;
            end
        end
    endtask

    // Reset register values: fires from slot boundaries, empty table compare,
    // every opcode, interval zero, the widest interval, signed overshoot and
    // the saturating next compare.
    task automatic test_arm_disarm_compare();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        // Compare on an empty table gives an idle summary.
        send_item(make_cmd(OP_CMP, 4'd0, 24'd0, 1'b0, 16'd0, 16'd0, 16'd0));
        send_item(make_cmd(OP_ARM, 4'd0, 24'd100, 1'b1, 16'hFFFF, 16'd0, 16'd0));
        send_item(make_cmd(OP_ARM, 4'd15, 24'hFFFFFF, 1'b0, 16'h0000, 16'hFFFF, 16'hFFFF));
        // A periodic slot with interval zero fires on every compare.
        send_item(make_cmd(OP_ARM, 4'd5, 24'd0, 1'b1, 16'h5A5A, 16'd0, 16'd0));
        send_item(make_cmd(OP_ARM, 4'd7, 24'd300, 1'b0, 16'h1234, 16'd0, 16'd0));
        // Dead opcode with every other field high: no result, no change.
        send_item(make_cmd(OP_UNUSED, 4'd15, 24'hFFFFFF, 1'b1, 16'hFFFF, 16'hFFFF,
                           16'hFFFF));
        // Slot 0 lands exactly on zero; slot 5 goes negative and drags the
        // minimum below the lead floor.
        send_item(make_cmd(OP_CMP, 4'd0, 24'd0, 1'b0, 16'd0, 16'd60, 16'd40));
        send_item(make_cmd(OP_DISARM, 4'd5, 24'd0, 1'b0, 16'd0, 16'd0, 16'd0));
        // Largest drop; counter plus lead runs past the top and saturates.
        send_item(make_cmd(OP_CMP, 4'd0, 24'd0, 1'b0, 16'd0, 16'hFFFF, 16'hFFFF));
        // Freeing the remaining slots keeps running set until the next compare.
        send_item(make_cmd(OP_DISARM, 4'd0, 24'd0, 1'b0, 16'd0, 16'd0, 16'd0));
        send_item(make_cmd(OP_DISARM, 4'd15, 24'd0, 1'b0, 16'd0, 16'd0, 16'd0));
        send_item(make_cmd(OP_CMP, 4'd0, 24'd0, 1'b0, 16'd0, 16'd10, 16'd10));
        send_item(make_cmd(OP_DISARM, 4'd3, 24'd0, 1'b0, 16'd0, 16'd0, 16'd0));
        // Re-arm after idling, then a one-shot fire that empties the table.
        send_item(make_cmd(OP_ARM, 4'd10, 24'd50, 1'b0, 16'hA5A5, 16'd0, 16'd0));
        send_item(make_cmd(OP_CMP, 4'd0, 24'd0, 1'b0, 16'd0, 16'd25, 16'd30));
    endtask

    // Register extremes at both ends, sender and receiver always ready.
    task automatic test_register_extremes();
        apply_setting(16'hFFFF, 16'd1, 10'd1023);
        run_random_phase(0, 0);
        apply_setting(16'd0, 16'hFFFF, 10'd0);
        run_random_phase(0, 0);
    endtask

    task automatic test_sender_gaps();
        apply_setting(16'd200, 16'd1000, 10'd5);
        run_random_phase(69, 0);
    endtask

    task automatic test_receiver_stalls();
        apply_setting(16'($urandom_range(2000)), 16'($urandom_range(65535, 1)),
                      10'($urandom_range(1023)));
        run_random_phase(0, 69);
    endtask

    task automatic test_both_idle();
        apply_setting(THRESHOLD_RST, MAX_COMPARE_RST, MIN_LEAD_RST);
        run_random_phase(17, 17);
    endtask

    initial begin
        for (int i = 0; i < SLOTS; i++) begin
            tbl_active[i] = 1'b0;
            tbl_periodic[i] = 1'b0;
            tbl_tag[i] = 16'd0;
            tbl_reload[i] = 24'd0;
            tbl_remaining[i] = 32'd0;
        end
        tbl_running = 1'b0;
        cfg_threshold = THRESHOLD_RST;
        cfg_max_compare = MAX_COMPARE_RST;
        cfg_min_lead = MIN_LEAD_RST;

        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_arm_disarm_compare();
        test_register_extremes();
        test_sender_gaps();
        test_receiver_stalls();
        test_both_idle();

        quiesce();
        if (timer_reports_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", timer_reports_q.size()));

        $display("tb: %0d items sent under %0d register settings and four idling mixes",
                 items_sent, settings_used);
        $display("tb: %0d results checked, %0d slot fires, %0d schedule summaries",
                 results_checked, fires_seen, summaries_seen);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/msct_pkg.sv
src/msct_ctrl.sv
src/msct_dp.sv
src/multi_slot_compare_timer_scheduler.sv
dv/tb_top.sv
